/* hdl/clsp_pkg.sv */
// ----------------------------------------------------------------------------
// clsp_pkg: shared definitions of the closed-loop stepper controller
// Operation codes, register indexes, sequencer steps, reset values and the
// structures passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package clsp_pkg;

   // Operation codes of an input item.
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_ENABLE  = 2'd1;
   localparam logic [1:0] OP_DISABLE = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [2:0] CSR_STEP_SCALE   = 3'd3;
   localparam logic [2:0] CSR_INTEG_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_CLOSED_MAX   = 3'd5;
   localparam logic [2:0] CSR_OPEN_CURRENT = 3'd6;
   localparam logic [2:0] CSR_CLOSED_LOOP  = 3'd7;

   // Register reset values.
   localparam logic [9:0]  RST_PROP_GAIN    = 10'd30;
   localparam logic [9:0]  RST_INTEG_GAIN   = 10'd10;
   localparam logic [9:0]  RST_DERIV_GAIN   = 10'd100;
   localparam logic [7:0]  RST_STEP_SCALE   = 8'd5;
   localparam logic [19:0] RST_INTEG_LIMIT  = 20'd65536;
   localparam logic [11:0] RST_CLOSED_MAX   = 12'd1023;
   localparam logic [11:0] RST_OPEN_CURRENT = 12'd1023;
   localparam logic        RST_CLOSED_LOOP  = 1'b1;

   // Default values of the top-level parameters.
   localparam int DEF_HOLD_TICKS   = 10000;
   localparam int DEF_FILTER_A     = 100;
   localparam int DEF_FILTER_B     = 28;
   localparam int DEF_COUNTER_SPAN = 65000;

   // Sequencer steps of one control tick.
   localparam logic [3:0] STEP_SPAN  = 4'd0;
   localparam logic [3:0] STEP_SCALE = 4'd1;
   localparam logic [3:0] STEP_CMD   = 4'd2;
   localparam logic [3:0] STEP_ERR   = 4'd3;
   localparam logic [3:0] STEP_IMUL  = 4'd4;
   localparam logic [3:0] STEP_INTEG = 4'd5;
   localparam logic [3:0] STEP_KD    = 4'd6;
   localparam logic [3:0] STEP_FA    = 4'd7;
   localparam logic [3:0] STEP_DERIV = 4'd8;
   localparam logic [3:0] STEP_OUT   = 4'd9;
   localparam logic [3:0] STEP_OPEN  = 4'd10;

   typedef struct packed {
      logic [9:0]  prop_gain;
      logic [9:0]  integ_gain;
      logic [9:0]  deriv_gain;
      logic [7:0]  step_scale;
      logic [19:0] integ_limit;
      logic [11:0] closed_current_max;
      logic [11:0] open_current;
      logic        closed_loop;
   } cfg_type;

   typedef struct packed {
      logic       in_load;
      logic       seed;
      logic       step_en;
      logic [3:0] step;
      logic       out_load;
      logic       out_zero;
   } cmd_type;

endpackage

/* hdl/closed_loop_stepper_pid_top.sv */
// ----------------------------------------------------------------------------
// closed_loop_stepper_pid_top: closed-loop stepper position controller
// PID position loop with open-loop fallback, one control tick per transfer.
// ----------------------------------------------------------------------------
// Each request transfer carries an operation: a control tick, an enable or a
// disable. A tick while enabled is stepped by the sequencer through the PID
// steps in closed-loop mode, or through the open-loop hold step after the
// commanded position in open-loop mode, before the result is offered; the
// sequencer runs the products of the tick through one shared 33 by 18 bit
// multiplier. An enable produces no result, a disable produces an all-zero
// result, and a tick while disabled is simply absorbed. The result waits in
// an output register, so a new request is accepted while the previous result
// has not yet been taken. Configuration registers are written through the
// csr port at any edge where csr_write_enable is high; they must only change
// while no tick is in flight.
module closed_loop_stepper_pid_top #(
   parameter int HOLD_TICKS   = clsp_pkg::DEF_HOLD_TICKS,
   parameter int FILTER_A     = clsp_pkg::DEF_FILTER_A,
   parameter int FILTER_B     = clsp_pkg::DEF_FILTER_B,
   parameter int COUNTER_SPAN = clsp_pkg::DEF_COUNTER_SPAN
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [13:0]        req_encoder_angle,
   input  logic [15:0]        req_step_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive_angle,
   output logic [11:0]        rsp_drive_current,
   output logic               rsp_error_flag,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_write_data
);
   import clsp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;

   // Register file: each write lands in the register selected by its index.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PROP_GAIN:    cfg_in.prop_gain          = csr_write_data[9:0];
            CSR_INTEG_GAIN:   cfg_in.integ_gain         = csr_write_data[9:0];
            CSR_DERIV_GAIN:   cfg_in.deriv_gain         = csr_write_data[9:0];
            CSR_STEP_SCALE:   cfg_in.step_scale         = csr_write_data[7:0];
            CSR_INTEG_LIMIT:  cfg_in.integ_limit        = csr_write_data;
            CSR_CLOSED_MAX:   cfg_in.closed_current_max = csr_write_data[11:0];
            CSR_OPEN_CURRENT: cfg_in.open_current       = csr_write_data[11:0];
            CSR_CLOSED_LOOP:  cfg_in.closed_loop        = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain          <= RST_PROP_GAIN;
         cfg_ff.integ_gain         <= RST_INTEG_GAIN;
         cfg_ff.deriv_gain         <= RST_DERIV_GAIN;
         cfg_ff.step_scale         <= RST_STEP_SCALE;
         cfg_ff.integ_limit        <= RST_INTEG_LIMIT;
         cfg_ff.closed_current_max <= RST_CLOSED_MAX;
         cfg_ff.open_current       <= RST_OPEN_CURRENT;
         cfg_ff.closed_loop        <= RST_CLOSED_LOOP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer owns the handshakes; the datapath only follows commands.
   clsp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .closed_loop (cfg_ff.closed_loop),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .cmd         (cmd)
   );

   clsp_datapath #(
      .HOLD_TICKS   (HOLD_TICKS),
      .FILTER_A     (FILTER_A),
      .FILTER_B     (FILTER_B),
      .COUNTER_SPAN (COUNTER_SPAN)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg_ff),
      .req_encoder_angle (req_encoder_angle),
      .req_step_count    (req_step_count),
      .rsp_drive_angle   (rsp_drive_angle),
      .rsp_drive_current (rsp_drive_current),
      .rsp_error_flag    (rsp_error_flag)
   );

`ifndef SYNTHESIS
   // An enable does no sequenced work, so the next request is taken at once.
   a_enable_no_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_ENABLE) |=> req_ready)
      else $error("request channel stalled after an enable transfer");

   // Open-loop results never report a clamped position error.
   a_open_no_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !cfg_ff.closed_loop) |-> !rsp_error_flag)
      else $error("error flag set on an open-loop result");

   // The offered current never exceeds the larger of the closed-loop maximum and the open-loop current.
   a_current_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_current <= cfg_ff.closed_current_max ||
                     rsp_drive_current <= cfg_ff.open_current))
      else $error("drive current above the configured limit");
`endif

endmodule

/* hdl/clsp_ctrl.sv */
// ----------------------------------------------------------------------------
// clsp_ctrl: sequencer of the closed-loop stepper controller
// Accepts input items, keeps the enable state, steps the datapath through a
// control tick and hands the result to the output register.
// ----------------------------------------------------------------------------
module clsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic                closed_loop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output clsp_pkg::cmd_type   cmd
);
   import clsp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       enabled_ff, enabled_in;
   logic       zero_ff, zero_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      enabled_in   = enabled_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.step     = step_ff;
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.in_load = 1'b1;
               case (req_op)
                  OP_TICK: begin
                     if (enabled_ff) begin
                        state_in = ST_RUN;
                        step_in  = STEP_SPAN;
                        zero_in  = 1'b0;
                     end
                  end
                  OP_ENABLE: begin
                     cmd.seed   = 1'b1;
                     enabled_in = 1'b1;
                  end
                  OP_DISABLE: begin
                     enabled_in = 1'b0;
                     zero_in    = 1'b1;
                     state_in   = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.step_en = 1'b1;
            if (step_ff == STEP_CMD && !closed_loop) begin
               step_in = STEP_OPEN;
            end else if (step_ff == STEP_OUT || step_ff == STEP_OPEN) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_zero = zero_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SPAN;
         enabled_ff   <= 1'b0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         enabled_ff   <= enabled_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/clsp_datapath.sv */
// ----------------------------------------------------------------------------
// clsp_datapath: arithmetic of the closed-loop stepper controller
// Position unwrapping, PID terms over one shared multiplier, open-loop hold
// logic and the output register, all driven by sequencer commands.
// ----------------------------------------------------------------------------
module clsp_datapath #(
   parameter int HOLD_TICKS   = clsp_pkg::DEF_HOLD_TICKS,
   parameter int FILTER_A     = clsp_pkg::DEF_FILTER_A,
   parameter int FILTER_B     = clsp_pkg::DEF_FILTER_B,
   parameter int COUNTER_SPAN = clsp_pkg::DEF_COUNTER_SPAN
) (
   input  logic                clock,
   input  logic                reset,
   input  clsp_pkg::cmd_type   cmd,
   input  clsp_pkg::cfg_type   cfg,
   input  logic [13:0]         req_encoder_angle,
   input  logic [15:0]         req_step_count,
   output logic signed [31:0]  rsp_drive_angle,
   output logic [11:0]         rsp_drive_current,
   output logic                rsp_error_flag
);
   import clsp_pkg::*;

   localparam logic [16:0] SPAN_C  = 17'(COUNTER_SPAN);
   localparam logic [16:0] FA_C    = 17'(FILTER_A);
   localparam logic [16:0] FB_C    = 17'(FILTER_B);
   localparam logic [13:0] HOLD_C  = 14'(HOLD_TICKS);
   localparam logic signed [17:0] HALF_C = 18'(COUNTER_SPAN / 2);
   localparam logic signed [50:0] I32_MAX = 51'sd2147483647;
   localparam logic signed [50:0] I32_MIN = -51'sd2147483648;

   // Division by a power of two that truncates toward zero.
   function automatic logic signed [50:0] div_pow2(input logic signed [50:0] x,
                                                  input logic [2:0] k);
      logic signed [50:0] bias;
      bias = x[50] ? $signed((51'd1 << k) - 51'd1) : 51'sd0;
      return (x + bias) >>> k;
   endfunction

   logic [13:0]        y_ff, y_in;
   logic [15:0]        s_ff, s_in;
   logic [15:0]        prev_step_ff, prev_step_in;
   logic [31:0]        step_base_ff, step_base_in;
   logic [31:0]        prev_cmd_ff, prev_cmd_in;
   logic [13:0]        prev_enc_ff, prev_enc_in;
   logic signed [31:0] prev_unw_ff, prev_unw_in;
   logic signed [15:0] turn_ff, turn_in;
   logic signed [20:0] integ_ff, integ_in;
   logic signed [31:0] deriv_ff, deriv_in;
   logic [13:0]        hold_ff, hold_in;
   logic signed [50:0] prod_ff, prod_in;
   logic [31:0]        r_ff, r_in;
   logic signed [31:0] yw_ff, yw_in;
   logic signed [11:0] e_ff, e_in;
   logic               flag_ff, flag_in;
   logic signed [31:0] vel_ff, vel_in;
   logic [16:0]        kd_ff, kd_in;
   logic signed [31:0] fa_ff, fa_in;
   logic [31:0]        res_angle_ff, res_angle_in;
   logic [11:0]        res_cur_ff, res_cur_in;
   logic               res_flag_ff, res_flag_in;
   logic [31:0]        out_angle_ff, out_angle_in;
   logic [11:0]        out_cur_ff, out_cur_in;
   logic               out_flag_ff, out_flag_in;

   logic signed [32:0] mul_a;
   logic [16:0]        mul_b;
   logic signed [50:0] mul_out;
   logic signed [17:0] d_step;
   logic signed [14:0] dy;
   logic signed [15:0] turn_new;
   logic signed [32:0] e_full;
   logic signed [50:0] quo;
   logic signed [23:0] isum, ilim, ilim_n;
   logic signed [50:0] dsum, usum;
   logic signed [50:0] umag;
   logic [31:0]        vel3;
   logic [13:0]        hold_new;

   assign mul_out = mul_a * $signed({1'b0, mul_b});

   always_comb begin
      y_in = y_ff; s_in = s_ff;
      prev_step_in = prev_step_ff; step_base_in = step_base_ff;
      prev_cmd_in = prev_cmd_ff; prev_enc_in = prev_enc_ff;
      prev_unw_in = prev_unw_ff; turn_in = turn_ff;
      integ_in = integ_ff; deriv_in = deriv_ff; hold_in = hold_ff;
      prod_in = prod_ff; r_in = r_ff; yw_in = yw_ff; e_in = e_ff;
      flag_in = flag_ff; vel_in = vel_ff; kd_in = kd_ff; fa_in = fa_ff;
      res_angle_in = res_angle_ff; res_cur_in = res_cur_ff;
      res_flag_in = res_flag_ff;
      out_angle_in = out_angle_ff; out_cur_in = out_cur_ff;
      out_flag_in = out_flag_ff;
      mul_a = '0; mul_b = '0;
      d_step = $signed({2'b0, s_ff}) - $signed({2'b0, prev_step_ff});
      dy = $signed({1'b0, y_ff}) - $signed({1'b0, prev_enc_ff});
      turn_new = turn_ff;
      e_full = '0; quo = '0; isum = '0; dsum = '0; usum = '0; umag = '0;
      ilim = $signed({4'b0, cfg.integ_limit});
      ilim_n = -ilim;
      vel3 = 32'(vel_ff) + (32'(vel_ff) << 1);
      hold_new = hold_ff;

      if (cmd.in_load) begin
         y_in = req_encoder_angle;
         s_in = req_step_count;
      end
      if (cmd.seed) begin
         step_base_in = {18'b0, req_encoder_angle};
         prev_step_in = '0;
         prev_cmd_in  = {18'b0, req_encoder_angle};
         prev_enc_in  = req_encoder_angle;
         prev_unw_in  = $signed({18'b0, req_encoder_angle});
         turn_in      = '0;
      end

      if (cmd.step_en) begin
         case (cmd.step)
            STEP_SPAN: begin
               mul_a = $signed({16'b0, SPAN_C});
               mul_b = {9'b0, cfg.step_scale};
               prod_in = mul_out;
            end
            STEP_SCALE: begin
               if (d_step < -HALF_C) begin
                  step_base_in = step_base_ff + prod_ff[31:0];
               end else if (d_step > HALF_C) begin
                  step_base_in = step_base_ff - prod_ff[31:0];
               end
               mul_a = $signed({17'b0, s_ff});
               mul_b = {9'b0, cfg.step_scale};
               prod_in = mul_out;
            end
            STEP_CMD: begin
               r_in = step_base_ff + prod_ff[31:0];
               prev_step_in = s_ff;
               if (dy > 15'sd8192) begin
                  turn_new = turn_ff - 16'sd1;
               end else if (dy < -15'sd8192) begin
                  turn_new = turn_ff + 16'sd1;
               end
               if (cfg.closed_loop) begin
                  turn_in = turn_new;
               end
               yw_in = $signed({{2{turn_new[15]}}, turn_new, 14'b0})
                       + $signed({18'b0, y_ff});
            end
            STEP_ERR: begin
               e_full = $signed({r_ff[31], r_ff}) - $signed({yw_ff[31], yw_ff});
               flag_in = 1'b0;
               if (e_full > 33'sd1638) begin
                  e_in = 12'sd1638;
                  flag_in = 1'b1;
               end else if (e_full < -33'sd1638) begin
                  e_in = -12'sd1638;
                  flag_in = 1'b1;
               end else begin
                  e_in = e_full[11:0];
               end
               vel_in = yw_ff - prev_unw_ff;
            end
            STEP_IMUL: begin
               mul_a = {{21{e_ff[11]}}, e_ff};
               mul_b = {7'b0, cfg.integ_gain};
               prod_in = mul_out;
            end
            STEP_INTEG: begin
               quo = div_pow2(prod_ff, 3'd5);
               isum = quo[23:0] + {{3{integ_ff[20]}}, integ_ff};
               if (isum > ilim) begin
                  integ_in = ilim[20:0];
               end else if (isum < ilim_n) begin
                  integ_in = ilim_n[20:0];
               end else begin
                  integ_in = isum[20:0];
               end
               mul_a = $signed({16'b0, FB_C});
               mul_b = {7'b0, cfg.deriv_gain};
               prod_in = mul_out;
            end
            STEP_KD: begin
               kd_in = prod_ff[16:0];
               mul_a = {deriv_ff[31], deriv_ff};
               mul_b = FA_C;
               prod_in = mul_out;
            end
            STEP_FA: begin
               quo = div_pow2(prod_ff, 3'd7);
               fa_in = quo[31:0];
               mul_a = {vel_ff[31], vel_ff};
               mul_b = kd_ff;
               prod_in = mul_out;
            end
            STEP_DERIV: begin
               dsum = {{19{fa_ff[31]}}, fa_ff} - div_pow2(prod_ff, 3'd3);
               if (dsum > I32_MAX) begin
                  deriv_in = I32_MAX[31:0];
               end else if (dsum < I32_MIN) begin
                  deriv_in = I32_MIN[31:0];
               end else begin
                  deriv_in = dsum[31:0];
               end
               mul_a = {{21{e_ff[11]}}, e_ff};
               mul_b = {7'b0, cfg.prop_gain};
               prod_in = mul_out;
            end
            STEP_OUT: begin
               usum = prod_ff + {{30{integ_ff[20]}}, integ_ff}
                      + {{19{deriv_ff[31]}}, deriv_ff};
               quo = div_pow2(usum, 3'd7);
               umag = quo[50] ? -quo : quo;
               if (quo == 51'sd0) begin
                  res_angle_in = {18'b0, y_ff};
               end else if (quo[50]) begin
                  res_angle_in = {18'b0, y_ff} - 32'd82 + vel3;
               end else begin
                  res_angle_in = {18'b0, y_ff} + 32'd82 + vel3;
               end
               if (umag > $signed({39'b0, cfg.closed_current_max})) begin
                  res_cur_in = cfg.closed_current_max;
               end else begin
                  res_cur_in = umag[11:0];
               end
               res_flag_in = flag_ff;
               prev_enc_in = y_ff;
               prev_unw_in = yw_ff;
            end
            STEP_OPEN: begin
               if (r_ff == prev_cmd_ff) begin
                  if (hold_ff < HOLD_C) begin
                     hold_new = hold_ff + 14'd1;
                  end
               end else begin
                  hold_new = '0;
               end
               hold_in = hold_new;
               res_cur_in = (hold_new >= HOLD_C) ? {1'b0, cfg.open_current[11:1]}
                                                 : cfg.open_current;
               res_angle_in = r_ff;
               res_flag_in = 1'b0;
               prev_cmd_in = r_ff;
            end
            default: ;
         endcase
      end

      if (cmd.out_load) begin
         out_angle_in = cmd.out_zero ? 32'd0  : res_angle_ff;
         out_cur_in   = cmd.out_zero ? 12'd0  : res_cur_ff;
         out_flag_in  = cmd.out_zero ? 1'b0   : res_flag_ff;
      end
   end

   // Controller state of the loop.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_step_ff <= '0;
         step_base_ff <= '0;
         prev_cmd_ff  <= '0;
         prev_enc_ff  <= '0;
         prev_unw_ff  <= '0;
         turn_ff      <= '0;
         integ_ff     <= '0;
         deriv_ff     <= '0;
         hold_ff      <= '0;
      end else begin
         prev_step_ff <= prev_step_in;
         step_base_ff <= step_base_in;
         prev_cmd_ff  <= prev_cmd_in;
         prev_enc_ff  <= prev_enc_in;
         prev_unw_ff  <= prev_unw_in;
         turn_ff      <= turn_in;
         integ_ff     <= integ_in;
         deriv_ff     <= deriv_in;
         hold_ff      <= hold_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      y_ff         <= y_in;
      s_ff         <= s_in;
      prod_ff      <= prod_in;
      r_ff         <= r_in;
      yw_ff        <= yw_in;
      e_ff         <= e_in;
      flag_ff      <= flag_in;
      vel_ff       <= vel_in;
      kd_ff        <= kd_in;
      fa_ff        <= fa_in;
      res_angle_ff <= res_angle_in;
      res_cur_ff   <= res_cur_in;
      res_flag_ff  <= res_flag_in;
      out_angle_ff <= out_angle_in;
      out_cur_ff   <= out_cur_in;
      out_flag_ff  <= out_flag_in;
   end

   assign rsp_drive_angle   = $signed(out_angle_ff);
   assign rsp_drive_current = out_cur_ff;
   assign rsp_error_flag    = out_flag_ff;

endmodule
